@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

@@ src/lphm_pkg.sv @@
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared constants, codes and bucket helpers of the hash multimap.
// ----------------------------------------------------------------------------
package lphm_pkg;

    localparam int BUCKETS = 1024;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int HASH_W  = 64;
    localparam int ENTRY_W = 32;
    localparam int OCC_W   = BKT_W + 1;
    localparam int WORD_W  = HASH_W + ENTRY_W;

    localparam logic [OCC_W-1:0]   LIMIT_RESET = OCC_W'(716);
    localparam logic [ENTRY_W-1:0] ENTRY_NONE  = '1;

    localparam logic [2:0] OP_INSERT     = 3'd0;
    localparam logic [2:0] OP_FIND_FIRST = 3'd1;
    localparam logic [2:0] OP_FIND_NEXT  = 3'd2;
    localparam logic [2:0] OP_REMOVE     = 3'd3;
    localparam logic [2:0] OP_REPLACE    = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_INVALID   = 3'd4;

    localparam logic [2:0] REG_LIMIT_ADDR = 3'd0;

    typedef logic [BKT_W-1:0] bkt_t;

    function automatic bkt_t home_of(input logic [HASH_W-1:0] h);
        return h[BKT_W-1:0];
    endfunction

    // Power-of-two table: wrap falls out of the bucket width
    function automatic bkt_t step_on(input bkt_t p);
        return BKT_W'(p + 1'b1);
    endfunction

    function automatic bkt_t gap(input bkt_t from, input bkt_t to);
        return BKT_W'(to - from);
    endfunction

endpackage

@@ src/lphm_ram.sv @@
// ----------------------------------------------------------------------------
// lphm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lphm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/linear_probe_hash_multimap_top.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_multimap_top
// Open-addressing hash multimap, linear probing, backward-shift removal.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tuser: operation; tdata: hash, ids, resume
// m_        out  m_tvalid/m_tready  tuser: status; tdata: bucket, entry, occ
// apb       in   psel/penable       entry_limit at byte address 0
//
// One item at a time: accept, walk the probe run one bucket per cycle through
// the registered RAM read port, then load the output register.
// Remove goes on past the match, pulling later items of the run back into the
// hole where they may move, then empties the last hole. Clear empties every bucket.
// After reset a clearing pass over all 1024 buckets runs before the first item.
// A full output register holds the sequencer in its response state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module linear_probe_hash_multimap_top
    import lphm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [63:0] key_hash, [95:64] entry_id, [127:96] new_entry_id,
    // [137:128] resume_bucket, [143:138] zero
    input  logic [143:0] s_tdata,
    // [2:0] operation
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [9:0] found_bucket, [41:10] found_entry, [52:42] occupancy, [55:53] zero
    output logic [55:0]  m_tdata,
    // [2:0] status
    output logic [2:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef enum logic [2:0] {
        S_SWEEP, S_IDLE, S_PROBE, S_SHIFT, S_FIN, S_RESP
    } state_t;

    localparam int MDATA_W = OCC_W + ENTRY_W + BKT_W;

    state_t               state_reg, state_next;
    logic [2:0]           op_reg, op_next;
    logic [HASH_W-1:0]    hash_reg, hash_next;
    logic [ENTRY_W-1:0]   eid_reg, eid_next;
    logic [ENTRY_W-1:0]   neid_reg, neid_next;
    bkt_t                 cur_reg, cur_next;
    bkt_t                 n_reg, n_next;
    bkt_t                 hole_reg, hole_next;
    logic [OCC_W-1:0]     occ_reg, occ_next;
    logic [OCC_W-1:0]     limit_reg, limit_next;
    logic [2:0]           res_status_reg, res_status_next;
    bkt_t                 res_bucket_reg, res_bucket_next;
    logic [ENTRY_W-1:0]   res_entry_reg, res_entry_next;
    logic                 sweep_resp_reg, sweep_resp_next;
    logic                 m_valid_reg, m_valid_next;
    logic [MDATA_W-1:0]   m_data_reg, m_data_next;
    logic [2:0]           m_user_reg, m_user_next;

    logic                 ram_we;
    bkt_t                 ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WORD_W-1:0]    ram_rdata;

    logic [HASH_W-1:0]    in_hash;
    logic [ENTRY_W-1:0]   in_eid;
    logic [ENTRY_W-1:0]   in_neid;
    bkt_t                 in_rb;
    logic                 accept;

    logic [HASH_W-1:0]    q_hash;
    logic [ENTRY_W-1:0]   q_entry;
    logic                 q_empty;
    logic                 q_match;
    bkt_t                 q_home;

    assign in_hash = s_tdata[63:0];
    assign in_eid  = s_tdata[95:64];
    assign in_neid = s_tdata[127:96];
    assign in_rb   = s_tdata[128 +: BKT_W];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign q_hash  = ram_rdata[WORD_W-1:ENTRY_W];
    assign q_entry = ram_rdata[ENTRY_W-1:0];
    assign q_empty = (q_entry == ENTRY_NONE);
    assign q_home  = home_of(q_hash);
    // Find matches on hash alone, the rest need the pair
    assign q_match = (q_hash == hash_reg) &&
                     ((op_reg == OP_FIND_FIRST) || (op_reg == OP_FIND_NEXT) ||
                      (q_entry == eid_reg));

    // Read address always tracks the bucket examined next cycle
    lphm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BUCKETS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cur_next),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        hash_next       = hash_reg;
        eid_next        = eid_reg;
        neid_next       = neid_reg;
        cur_next        = cur_reg;
        n_next          = n_reg;
        hole_next       = hole_reg;
        occ_next        = occ_reg;
        limit_next      = limit_reg;
        res_status_next = res_status_reg;
        res_bucket_next = res_bucket_reg;
        res_entry_next  = res_entry_reg;
        sweep_resp_next = sweep_resp_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        ram_we          = 1'b0;
        ram_waddr       = hole_reg;
        ram_wdata       = {{HASH_W{1'b0}}, ENTRY_NONE};

        // Register writes must land only while idle; the block does not enforce it
        if (psel && penable && pwrite && (paddr == REG_LIMIT_ADDR)) begin
            limit_next = pwdata[OCC_W-1:0];
        end

        unique case (state_reg)
            S_SWEEP: begin
                // Empty one bucket per cycle
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                cur_next  = step_on(cur_reg);
                if (cur_reg == BKT_W'(BUCKETS - 1)) begin
                    occ_next        = '0;
                    sweep_resp_next = 1'b0;
                    state_next      = sweep_resp_reg ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    op_next         = s_tuser;
                    hash_next       = in_hash;
                    eid_next        = in_eid;
                    neid_next       = in_neid;
                    n_next          = '0;
                    res_bucket_next = '0;
                    res_entry_next  = '0;
                    res_status_next = ST_NOT_FOUND;
                    cur_next        = home_of(in_hash);
                    state_next      = S_RESP;
                    unique case (s_tuser)
                        OP_INSERT: begin
                            if (in_eid == ENTRY_NONE) begin
                                res_status_next = ST_INVALID;
                            end else if (occ_reg >= limit_reg ||
                                         occ_reg >= OCC_W'(BUCKETS)) begin
                                res_status_next = ST_FULL;
                            end else begin
                                state_next = S_PROBE;
                            end
                        end
                        OP_FIND_FIRST: begin
                            state_next = S_PROBE;
                        end
                        OP_FIND_NEXT: begin
                            cur_next   = step_on(in_rb);
                            state_next = S_PROBE;
                        end
                        OP_REMOVE: begin
                            if (in_eid != ENTRY_NONE) begin
                                state_next = S_PROBE;
                            end
                        end
                        OP_REPLACE: begin
                            if (in_neid == ENTRY_NONE) begin
                                res_status_next = ST_INVALID;
                            end else if (in_eid != ENTRY_NONE) begin
                                state_next = S_PROBE;
                            end
                        end
                        OP_CLEAR: begin
                            cur_next        = '0;
                            sweep_resp_next = 1'b1;
                            res_status_next = ST_OK;
                            state_next      = S_SWEEP;
                        end
                        default: begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_PROBE: begin
                if (q_empty) begin
                    state_next = S_RESP;
                    if (op_reg == OP_INSERT) begin
                        ram_we          = 1'b1;
                        ram_waddr       = cur_reg;
                        ram_wdata       = {hash_reg, eid_reg};
                        occ_next        = OCC_W'(occ_reg + 1'b1);
                        res_status_next = ST_OK;
                        res_bucket_next = cur_reg;
                        res_entry_next  = eid_reg;
                    end
                end else if (q_match) begin
                    state_next = S_RESP;
                    case (op_reg)
                        OP_INSERT: begin
                            res_status_next = ST_DUPLICATE;
                        end
                        OP_REPLACE: begin
                            ram_we          = 1'b1;
                            ram_waddr       = cur_reg;
                            ram_wdata       = {hash_reg, neid_reg};
                            res_status_next = ST_OK;
                            res_bucket_next = cur_reg;
                            res_entry_next  = neid_reg;
                        end
                        OP_REMOVE: begin
                            // Open a hole here and pull the run back into it
                            hole_next       = cur_reg;
                            cur_next        = step_on(cur_reg);
                            n_next          = BKT_W'(1);
                            res_status_next = ST_OK;
                            res_bucket_next = cur_reg;
                            res_entry_next  = eid_reg;
                            state_next      = S_SHIFT;
                        end
                        default: begin
                            res_status_next = ST_OK;
                            res_bucket_next = cur_reg;
                            res_entry_next  = q_entry;
                        end
                    endcase
                end else if (n_reg == BKT_W'(BUCKETS - 1)) begin
                    // Whole table walked without a hit
                    state_next      = S_RESP;
                    res_status_next = (op_reg == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
                end else begin
                    cur_next = step_on(cur_reg);
                    n_next   = BKT_W'(n_reg + 1'b1);
                end
            end
            S_SHIFT: begin
                if (q_empty) begin
                    state_next = S_FIN;
                end else begin
                    // Move back only if the hole lies nearer the item's home
                    if (gap(q_home, hole_reg) < gap(q_home, cur_reg)) begin
                        ram_we    = 1'b1;
                        ram_waddr = hole_reg;
                        ram_wdata = ram_rdata;
                        hole_next = cur_reg;
                    end
                    if (n_reg == BKT_W'(BUCKETS - 1)) begin
                        state_next = S_FIN;
                    end else begin
                        cur_next = step_on(cur_reg);
                        n_next   = BKT_W'(n_reg + 1'b1);
                    end
                end
            end
            S_FIN: begin
                ram_we    = 1'b1;
                ram_waddr = hole_reg;
                if (occ_reg != '0) begin
                    occ_next = OCC_W'(occ_reg - 1'b1);
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {occ_reg, res_entry_reg, res_bucket_reg};
                    m_user_next  = res_status_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_SWEEP;
            cur_reg        <= '0;
            n_reg          <= '0;
            occ_reg        <= '0;
            limit_reg      <= LIMIT_RESET;
            sweep_resp_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            n_reg          <= n_next;
            occ_reg        <= occ_next;
            limit_reg      <= limit_next;
            sweep_resp_reg <= sweep_resp_next;
            m_valid_reg    <= m_valid_next;
        end
        op_reg         <= op_next;
        hash_reg       <= hash_next;
        eid_reg        <= eid_next;
        neid_reg       <= neid_next;
        hole_reg       <= hole_next;
        res_status_reg <= res_status_next;
        res_bucket_reg <= res_bucket_next;
        res_entry_reg  <= res_entry_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(56 - MDATA_W){1'b0}}, m_data_reg};
    assign m_tuser  = m_user_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_LIMIT_ADDR) ? {{(32 - OCC_W){1'b0}}, limit_reg} : '0;

    `ASSERT_NEVER(a_occ_bound, aclk, aresetn, occ_reg > OCC_W'(BUCKETS), "occupancy beyond table size")
    `ASSERT_CLK(a_clear_sweeps, aclk, aresetn, (accept && s_tuser == OP_CLEAR) |=> (state_reg == S_SWEEP), "clear did not start sweep")
    `ASSERT_NEVER(a_hole_behind, aclk, aresetn, (state_reg == S_SHIFT) && (hole_reg == cur_reg), "hole caught up with scan")
    `ASSERT_CLK(a_resp_loads, aclk, aresetn, (state_reg == S_RESP && (!m_valid_reg || m_tready)) |=> (m_valid_reg && state_reg == S_IDLE), "result not loaded")

endmodule
